/* rtl/sdi_pkg.sv */
`timescale 1ns / 1ps

package sdi_pkg;

  localparam int STATE_W    = 32;
  localparam int NOISE_W    = 16;
  localparam int NOISE_FRAC = NOISE_W - 4;
  localparam int FRAC       = 24;
  localparam int PHASE_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int OUT_W      = 32;
  localparam int COS_DEPTH  = 1024;
  localparam int COS_IDX_W  = $clog2(COS_DEPTH);

  localparam int HD_W   = 26;
  localparam int HK_W   = 26;
  localparam int DF_W   = 25;
  localparam int KS_W   = 25;
  localparam int MD_W   = 25;
  localparam int DUFF_W = 26;

  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = $clog2(NUM_REGS * 4);
  localparam int CFG_DW   = 32;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  localparam logic [REG_IDX_W-1:0] REG_HALF_DRIFT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HALF_KICK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KICK_SCALE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MOD_DEPTH   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DUFFING     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_START = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_RAMP  = 3'd7;

  localparam logic [HD_W-1:0]   HD_RST   = HD_W'(5270718);
  localparam logic [HK_W-1:0]   HK_RST   = HK_W'(5270718);
  localparam logic [DF_W-1:0]   DF_RST   = DF_W'(16694272);
  localparam logic [KS_W-1:0]   KS_RST   = KS_W'(1664000);
  localparam logic [MD_W-1:0]   MD_RST   = MD_W'(671089);
  localparam logic [DUFF_W-1:0] DUFF_RST = '0;

  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [STATE_W-1:0] cos_rom_t [COS_DEPTH];

  // Q8.24 cosine of 2*pi*k/COS_DEPTH, Taylor series in Q2.30
  function automatic logic signed [STATE_W-1:0] cos_entry(input int unsigned k);
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] c;
    logic neg;
    th   = (TWO_PI_Q30 * 64'(k)) / 64'(COS_DEPTH);
    neg  = 1'b0;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    if (th > PI_Q30) th = TWO_PI_Q30 - th;
    if (th > HALF_PI_Q30) begin
      th  = PI_Q30 - th;
      neg = 1'b1;
    end
    t2 = (th * th) >> 30;
    for (int n = 1; n <= 9; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    c = (sum + 64'sd32) >>> 6;
    if (neg) c = -c;
    return c[STATE_W-1:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k < COS_DEPTH; k++) begin
      rom[k] = cos_entry(k);
    end
    return rom;
  endfunction

endpackage

/* rtl/stochastic_duffing_integrator_core.sv */
`timescale 1ns / 1ps

// Channel    Dir  Accepted at               Beat contents (lsb up)
// s_axis     in   s_axis_tvalid&tready      tdata: noise_sample[15:0]
// m_axis     out  m_axis_tvalid&tready      tdata: position, velocity, step_number
//                                           tuser: particle_lost
// apb        in   psel&penable&pwrite       8 registers at byte address 4*i
//
// A step runs from accept through a cosine ROM read, then 13 multiply ops (multiply, then
// round, saturate and accumulate) on the single shared multiplier, and a final post.
// s_axis_tready is high only while idle. A finished step waits in the output register;
// the next step may run meanwhile and holds at its end until that register is free.
// Reset clears state, loads register defaults and empties the output register.
module stochastic_duffing_integrator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sdi_pkg::NOISE_W-1:0]        s_axis_tdata,  // noise_sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [3*sdi_pkg::OUT_W-1:0]        m_axis_tdata,  // position, velocity, step_number
  output logic                               m_axis_tuser,  // particle_lost
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sdi_pkg::CFG_AW-1:0]         paddr,
  input  logic [sdi_pkg::CFG_DW-1:0]         pwdata,
  output logic [sdi_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int W  = sdi_pkg::STATE_W;
  localparam int PW = 2 * sdi_pkg::STATE_W;
  localparam sdi_pkg::cos_rom_t CosRom = sdi_pkg::build_cos_rom();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COS,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_MODC    = 4'd0,
    OP_K1_X2   = 4'd1,
    OP_K1_K    = 4'd2,
    OP_K1_F    = 4'd3,
    OP_K1_V    = 4'd4,
    OP_DRIFT1  = 4'd5,
    OP_DAMP    = 4'd6,
    OP_NOISE   = 4'd7,
    OP_DRIFT2  = 4'd8,
    OP_K2_X2   = 4'd9,
    OP_K2_K    = 4'd10,
    OP_K2_F    = 4'd11,
    OP_K2_V    = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    DST_BASE,
    DST_TMP,
    DST_V,
    DST_X
  } dst_e;

  state_e state_q;
  op_e    op_q;

  logic [sdi_pkg::HD_W-1:0]   half_drift_q;
  logic [sdi_pkg::HK_W-1:0]   half_kick_q;
  logic [sdi_pkg::DF_W-1:0]   damping_q;
  logic [sdi_pkg::KS_W-1:0]   kick_scale_q;
  logic [sdi_pkg::MD_W-1:0]   mod_depth_q;
  logic [sdi_pkg::DUFF_W-1:0] duffing_q;
  logic [sdi_pkg::PHASE_W-1:0] phase_start_q;
  logic [sdi_pkg::PHASE_W-1:0] phase_ramp_q;

  logic signed [W-1:0] x_q, v_q, base_q, tmp_q, cos_q;
  logic signed [sdi_pkg::NOISE_W-1:0] noise_q;
  logic [sdi_pkg::PHASE_W-1:0] phase_q, incr_q;
  logic [sdi_pkg::COUNT_W-1:0] step_q;
  logic lost_q;

  logic [PW-1:0] mag_q;
  logic          neg_q;

  logic                        out_valid_q;
  logic [3*sdi_pkg::OUT_W-1:0] out_data_q;
  logic                        out_lost_q;

  logic signed [W-1:0] a_val, b_val, c_val;
  logic                sub_op, sh12;
  dst_e                dst;

  logic [W-1:0]  a_mag, b_mag;
  logic [PW-1:0] rnd, r, lim, r_cl;
  logic          ovf;
  logic signed [W:0]   pv;
  logic signed [W+1:0] sum;
  logic                sum_hi, sum_lo;
  logic signed [W-1:0] res;

  logic cfg_wr;
  logic [sdi_pkg::REG_IDX_W-1:0] cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[sdi_pkg::CFG_AW-1:2];
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      sdi_pkg::REG_HALF_DRIFT:  prdata = sdi_pkg::CFG_DW'(half_drift_q);
      sdi_pkg::REG_HALF_KICK:   prdata = sdi_pkg::CFG_DW'(half_kick_q);
      sdi_pkg::REG_DAMPING:     prdata = sdi_pkg::CFG_DW'(damping_q);
      sdi_pkg::REG_KICK_SCALE:  prdata = sdi_pkg::CFG_DW'(kick_scale_q);
      sdi_pkg::REG_MOD_DEPTH:   prdata = sdi_pkg::CFG_DW'(mod_depth_q);
      sdi_pkg::REG_DUFFING:     prdata = sdi_pkg::CFG_DW'($signed(duffing_q));
      sdi_pkg::REG_PHASE_START: prdata = sdi_pkg::CFG_DW'(phase_start_q);
      sdi_pkg::REG_PHASE_RAMP:  prdata = sdi_pkg::CFG_DW'(phase_ramp_q);
      default:                  prdata = '0;
    endcase
  end

  // cosine ROM, registered read
  always_ff @(posedge clk_i) begin
    cos_q <= CosRom[phase_q[sdi_pkg::PHASE_W-1 -: sdi_pkg::COS_IDX_W]];
  end

  // op table: r = sat(c +/- mulsh(a, b))
  always_comb begin
    a_val  = '0;
    b_val  = '0;
    c_val  = '0;
    sub_op = 1'b0;
    sh12   = 1'b0;
    dst    = DST_TMP;
    case (op_q)
      OP_MODC: begin
        a_val = W'($signed({1'b0, mod_depth_q}));
        b_val = cos_q;
        c_val = W'(1) <<< sdi_pkg::FRAC;
        dst   = DST_BASE;
      end
      OP_K1_X2, OP_K2_X2: begin
        a_val = x_q;
        b_val = x_q;
      end
      OP_K1_K, OP_K2_K: begin
        a_val = W'($signed(duffing_q));
        b_val = tmp_q;
        c_val = base_q;
      end
      OP_K1_F, OP_K2_F: begin
        a_val = tmp_q;
        b_val = x_q;
      end
      OP_K1_V, OP_K2_V: begin
        a_val  = W'($signed({1'b0, half_kick_q}));
        b_val  = tmp_q;
        c_val  = v_q;
        sub_op = 1'b1;
        dst    = DST_V;
      end
      OP_DRIFT1, OP_DRIFT2: begin
        a_val = W'($signed({1'b0, half_drift_q}));
        b_val = v_q;
        c_val = x_q;
        dst   = DST_X;
      end
      OP_DAMP: begin
        a_val = W'($signed({1'b0, damping_q}));
        b_val = v_q;
      end
      OP_NOISE: begin
        a_val = W'($signed({1'b0, kick_scale_q}));
        b_val = W'(noise_q);
        c_val = tmp_q;
        sh12  = 1'b1;
        dst   = DST_V;
      end
      default: begin
        dst = DST_TMP;
      end
    endcase
  end

  assign a_mag = a_val[W-1] ? W'(-a_val) : W'(a_val);
  assign b_mag = b_val[W-1] ? W'(-b_val) : W'(b_val);

  always_comb begin
    rnd  = mag_q + (sh12 ? (PW'(1) << (sdi_pkg::NOISE_FRAC - 1))
                         : (PW'(1) << (sdi_pkg::FRAC - 1)));
    r    = sh12 ? (rnd >> sdi_pkg::NOISE_FRAC) : (rnd >> sdi_pkg::FRAC);
    lim  = neg_q ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    ovf  = r > lim;
    r_cl = ovf ? lim : r;
    pv   = neg_q ? -$signed({1'b0, r_cl[W-1:0]}) : $signed({1'b0, r_cl[W-1:0]});
    sum  = sub_op ? ((W+2)'(c_val) - (W+2)'(pv)) : ((W+2)'(c_val) + (W+2)'(pv));
    sum_hi = sum > (W+2)'((W+2)'(1) <<< (W - 1)) - (W+2)'(1);
    sum_lo = sum < -((W+2)'(1) <<< (W - 1));
    if (sum_hi)      res = {1'b0, {(W-1){1'b1}}};
    else if (sum_lo) res = {1'b1, {(W-1){1'b0}}};
    else             res = sum[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_MODC;
      half_drift_q  <= sdi_pkg::HD_RST;
      half_kick_q   <= sdi_pkg::HK_RST;
      damping_q     <= sdi_pkg::DF_RST;
      kick_scale_q  <= sdi_pkg::KS_RST;
      mod_depth_q   <= sdi_pkg::MD_RST;
      duffing_q     <= sdi_pkg::DUFF_RST;
      phase_start_q <= '0;
      phase_ramp_q  <= '0;
      x_q           <= '0;
      v_q           <= '0;
      phase_q       <= '0;
      incr_q        <= '0;
      step_q        <= '0;
      lost_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != ST_DONE) out_valid_q <= 1'b0;

      if (cfg_wr) begin
        case (cfg_idx)
          sdi_pkg::REG_HALF_DRIFT:  half_drift_q <= pwdata[sdi_pkg::HD_W-1:0];
          sdi_pkg::REG_HALF_KICK:   half_kick_q  <= pwdata[sdi_pkg::HK_W-1:0];
          sdi_pkg::REG_DAMPING:     damping_q    <= pwdata[sdi_pkg::DF_W-1:0];
          sdi_pkg::REG_KICK_SCALE:  kick_scale_q <= pwdata[sdi_pkg::KS_W-1:0];
          sdi_pkg::REG_MOD_DEPTH:   mod_depth_q  <= pwdata[sdi_pkg::MD_W-1:0];
          sdi_pkg::REG_DUFFING:     duffing_q    <= pwdata[sdi_pkg::DUFF_W-1:0];
          sdi_pkg::REG_PHASE_START: begin
            phase_start_q <= pwdata[sdi_pkg::PHASE_W-1:0];
            incr_q        <= pwdata[sdi_pkg::PHASE_W-1:0];
          end
          sdi_pkg::REG_PHASE_RAMP:  phase_ramp_q <= pwdata[sdi_pkg::PHASE_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            noise_q <= s_axis_tdata;
            op_q    <= OP_MODC;
            state_q <= ST_COS;
          end
        end
        ST_COS: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          mag_q   <= PW'(a_mag) * PW'(b_mag);
          neg_q   <= a_val[W-1] ^ b_val[W-1];
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (ovf || sum_hi || sum_lo) lost_q <= 1'b1;
          case (dst)
            DST_BASE: base_q <= res;
            DST_TMP:  tmp_q  <= res;
            DST_V:    v_q    <= res;
            DST_X:    x_q    <= res;
            default:  tmp_q  <= res;
          endcase
          if (op_q == OP_K2_V) begin
            state_q <= ST_DONE;
          end else begin
            op_q    <= op_e'(op_q + 4'd1);
            state_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {step_q, sdi_pkg::OUT_W'(v_q), sdi_pkg::OUT_W'(x_q)};
            out_lost_q  <= lost_q;
            phase_q     <= phase_q + incr_q;
            incr_q      <= incr_q + phase_ramp_q;
            step_q      <= step_q + sdi_pkg::COUNT_W'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_lost_q;

endmodule
